>>> rtl/psu_pkg.sv
`default_nettype none

package psu_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned CFG_DATA_W = ROW_BYTES_W;
  localparam int unsigned CFG_IDX_W  = 1;

  // Depth of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_ROW_BYTES       = 1'b1
  } psu_reg_e;

  // Scanline filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filt_e;

  localparam logic [BYTE_W-1:0] FILT_MAX   = 8'd4;
  localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

  // Classified request handed from front to back (column travels beside it)
  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    psu_filt_e         filt;
    logic              first_row;
    logic              row_end;
    logic              bad;
  } psu_item_t;

endpackage

`default_nettype wire

>>> rtl/psu_ram.sv
`default_nettype none

module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/psu_queue.sv
`default_nettype none

module psu_queue #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] head_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/psu_front.sv
`default_nettype none

module psu_front
  import psu_pkg::*;
#(
  parameter int unsigned AW = 13
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [BYTE_W-1:0] raw_byte_i,
  input  wire logic              start_of_image_i,
  input  wire logic [AW:0]       row_bytes_i,
  output logic                   push_o,
  output psu_item_t              push_item_o,
  output logic      [AW-1:0]     push_col_o,
  input  wire logic              full_i
);

  logic          accept;
  logic [AW-1:0] col_q, col_d, col_e;
  psu_filt_e     filt_q, filt_d;
  logic          await_q, await_d, await_e;
  logic          first_q, first_d, first_e;
  logic          err_q, err_d, err_e;
  logic [AW:0]   col_inc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Start of image clears the row and error state before the byte is classified
  always_comb begin
    col_e   = start_of_image_i ? '0   : col_q;
    await_e = start_of_image_i ? 1'b1 : await_q;
    first_e = start_of_image_i ? 1'b1 : first_q;
    err_e   = start_of_image_i ? 1'b0 : err_q;
  end

  assign col_inc = {1'b0, col_e} + (AW + 1)'(1);

  // Classify the byte: filter type, bad filter, or data for the back end
  always_comb begin
    col_d       = col_q;
    filt_d      = filt_q;
    await_d     = await_q;
    first_d     = first_q;
    err_d       = err_q;
    push_o      = 1'b0;
    push_col_o  = col_e;
    push_item_o = '{raw: raw_byte_i, filt: filt_q, first_row: first_e,
                    row_end: 1'b0, bad: 1'b0};
    if (accept) begin
      col_d   = col_e;
      await_d = await_e;
      first_d = first_e;
      err_d   = err_e;
      if (!err_e) begin
        if (await_e) begin
          if (raw_byte_i > FILT_MAX) begin
            err_d           = 1'b1;
            push_o          = 1'b1;
            push_item_o.bad = 1'b1;
          end else begin
            filt_d  = psu_filt_e'(raw_byte_i[2:0]);
            await_d = 1'b0;
            col_d   = '0;
          end
        end else begin
          push_o = 1'b1;
          if (col_inc >= row_bytes_i) begin
            push_item_o.row_end = 1'b1;
            col_d   = '0;
            await_d = 1'b1;
            first_d = 1'b0;
          end else begin
            col_d = col_inc[AW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      filt_q  <= FILT_NONE;
      await_q <= 1'b1;
      first_q <= 1'b1;
      err_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      filt_q  <= filt_d;
      await_q <= await_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/psu_back.sv
`default_nettype none

module psu_back
  import psu_pkg::*;
#(
  parameter int unsigned AW = 13,
  parameter int unsigned HW = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire psu_item_t         head_item_i,
  input  wire logic [AW-1:0]     head_col_i,
  output logic                   pop_o,
  input  wire logic [HW:0]       bpp_i,
  output logic                   ram_we_o,
  output logic      [AW-1:0]     ram_waddr_o,
  output logic      [BYTE_W-1:0] ram_wdata_o,
  output logic                   ram_re_o,
  output logic      [AW-1:0]     ram_raddr_o,
  input  wire logic [BYTE_W-1:0] ram_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [BYTE_W-1:0] pixel_byte_o,
  output logic                   row_end_o,
  output logic                   bad_filter_o
);

  localparam int unsigned NH = 2 ** HW;
  localparam int unsigned CW = AW + HW + 1;

  // Work stage
  logic              s1_v_q, s1_v_d;
  psu_item_t         s1_item_q;
  logic [AW-1:0]     s1_col_q;
  logic              byp_q, byp_d;
  logic [BYTE_W-1:0] byp_dat_q;

  // Output register
  logic              out_v_q, out_v_d;
  logic [BYTE_W-1:0] pix_q;
  logic              row_end_q, bad_q;

  // Neighbor histories, newest first
  logic [BYTE_W-1:0] lh_q [NH];
  logic [BYTE_W-1:0] ulh_q [NH];

  logic              out_free, s1_adv, s1_data;
  logic [HW-1:0]     hidx;
  logic              left_ok;
  logic [BYTE_W-1:0] a, b, c, v;
  logic [BYTE_W:0]   ab_sum;
  logic [BYTE_W+1:0] ab_w, cc_w, pa, pb, pc;
  logic [BYTE_W-1:0] pred;

  assign out_free = !out_v_q || !out_stall_i;
  assign s1_adv   = s1_v_q && out_free;
  assign s1_data  = !s1_item_q.bad;
  assign pop_o    = !empty_i && (!s1_v_q || s1_adv);

  // Issue the line buffer read as the request enters the work stage
  assign ram_re_o    = pop_o;
  assign ram_raddr_o = head_col_i;

  // Forward a byte written at the same edge the read was issued
  assign byp_d = s1_adv && s1_data && (s1_col_q == head_col_i);

  // Gather neighbors
  assign hidx    = HW'(bpp_i - (HW + 1)'(1));
  assign left_ok = CW'(s1_col_q) >= CW'(bpp_i);
  assign b = s1_item_q.first_row ? '0 : (byp_q ? byp_dat_q : ram_rdata_i);
  assign a = left_ok ? lh_q[hidx]  : '0;
  assign c = left_ok ? ulh_q[hidx] : '0;

  // Paeth distances
  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign ab_w   = {1'b0, ab_sum};
  assign cc_w   = {1'b0, c, 1'b0};
  assign pa = (b >= c) ? (BYTE_W + 2)'(b - c) : (BYTE_W + 2)'(c - b);
  assign pb = (a >= c) ? (BYTE_W + 2)'(a - c) : (BYTE_W + 2)'(c - a);
  assign pc = (ab_w >= cc_w) ? (ab_w - cc_w) : (cc_w - ab_w);

  // Select predictor by filter type
  always_comb begin
    unique case (s1_item_q.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[BYTE_W:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = '0;
    endcase
  end

  assign v = (s1_item_q.raw + pred) & BYTE_MASK;

  // Write back the rebuilt byte as it leaves the work stage
  assign ram_we_o    = s1_adv && s1_data;
  assign ram_waddr_o = s1_col_q;
  assign ram_wdata_o = v;

  always_comb begin
    s1_v_d = s1_v_q;
    if (pop_o) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (s1_adv) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Load the work stage
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= head_item_i;
      s1_col_q  <= head_col_i;
      byp_q     <= byp_d;
      byp_dat_q <= v;
    end
  end

  // Load the output register; the error result carries a zero byte
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pix_q     <= s1_data ? v : '0;
      row_end_q <= s1_data && s1_item_q.row_end;
      bad_q     <= s1_item_q.bad;
    end
  end

  // Shift histories on every rebuilt byte
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_data) begin
      lh_q[0]  <= v;
      ulh_q[0] <= b;
      for (int i = 1; i < NH; i++) begin
        lh_q[i]  <= lh_q[i-1];
        ulh_q[i] <= ulh_q[i-1];
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign pixel_byte_o = pix_q;
  assign row_end_o    = row_end_q;
  assign bad_filter_o = bad_q;

endmodule

`default_nettype wire

>>> rtl/png_scanline_unfilter.sv
`default_nettype none

// PNG scanline unfilter for 8-bit samples. Each accepted byte is either a
// filter type (start of a scanline, no result) or filtered data that yields
// one rebuilt byte with a row-end mark; a filter type above 4 yields a single
// bad_filter result and the rest of the image is dropped until the next byte
// marked start_of_image. The block sustains one byte per clock while the
// output is not stalled: the front end classifies and counts columns in the
// accept cycle, a small request queue absorbs short stalls, and the back end
// issues the line-buffer read as a request leaves the queue and rebuilds
// the byte in the following cycle, writing it back to the line buffer
// (2**$clog2(MAX_ROW_BYTES) bytes) as it moves to the output register. A result
// passes through the request queue, the work stage and the output register.
// The line buffer holds the previous row; nothing in it is cleared, and the
// first row of each image reads zero above. Write configuration only while no
// results are pending.
module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES       = 8192,
  parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     raw_byte_i,
  input  wire logic                  start_of_image_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [BYTE_W-1:0]     pixel_byte_o,
  output logic                       row_end_o,
  output logic                       bad_filter_o
);

  localparam int unsigned AW   = $clog2(MAX_ROW_BYTES);
  localparam int unsigned HW   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
  localparam int unsigned RCW  = (AW + 1 > ROW_BYTES_W) ? AW + 1 : ROW_BYTES_W;
  localparam int unsigned BCW  = (HW + 1 > BPP_W) ? HW + 1 : BPP_W;
  localparam int unsigned QW   = $bits(psu_item_t) + AW;

  logic [BPP_W-1:0]       bpp_q;
  logic [ROW_BYTES_W-1:0] rb_q;
  logic [HW:0]            bpp_eff;
  logic [AW:0]            rb_eff;

  logic              push, full, pop, empty;
  psu_item_t         push_item, head_item;
  logic [AW-1:0]     push_col, head_col;
  logic [QW-1:0]     head_word;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BPP_W'(4);
      rb_q  <= ROW_BYTES_W'(4);
    end else if (cfg_we_i) begin
      unique case (psu_reg_e'(cfg_idx_i))
        REG_BYTES_PER_PIXEL: bpp_q <= cfg_wdata_i[BPP_W-1:0];
        REG_ROW_BYTES:       rb_q  <= cfg_wdata_i[ROW_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into their working ranges
  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = (HW + 1)'(1);
    end else if (BCW'(bpp_q) > BCW'(MAX_BYTES_PER_PIXEL)) begin
      bpp_eff = (HW + 1)'(MAX_BYTES_PER_PIXEL);
    end else begin
      bpp_eff = (HW + 1)'(bpp_q);
    end
    if (rb_q == '0) begin
      rb_eff = (AW + 1)'(1);
    end else if (RCW'(rb_q) > RCW'(MAX_ROW_BYTES)) begin
      rb_eff = (AW + 1)'(MAX_ROW_BYTES);
    end else begin
      rb_eff = (AW + 1)'(rb_q);
    end
  end

  psu_front #(
    .AW(AW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_byte_i       (raw_byte_i),
    .start_of_image_i (start_of_image_i),
    .row_bytes_i      (rb_eff),
    .push_o           (push),
    .push_item_o      (push_item),
    .push_col_o       (push_col),
    .full_i           (full)
  );

  psu_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_item, push_col}),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_word),
    .empty_o     (empty)
  );

  assign head_item = psu_item_t'(head_word[QW-1:AW]);
  assign head_col  = head_word[AW-1:0];

  psu_back #(
    .AW(AW),
    .HW(HW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_item_i  (head_item),
    .head_col_i   (head_col),
    .pop_o        (pop),
    .bpp_i        (bpp_eff),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_byte_o (pixel_byte_o),
    .row_end_o    (row_end_o),
    .bad_filter_o (bad_filter_o)
  );

  // Previous-row line buffer
  psu_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 ** AW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
